>>> sv/fifo_block_replacement_assert.svh
// Assertion macros for the block replacement unit.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FIFO_BLOCK_REPLACEMENT_ASSERT_SVH
`define FIFO_BLOCK_REPLACEMENT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FBR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbr check failed");

// Consequent checked in the cycle after the antecedent.
`define FBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbr check failed");

`endif

>>> sv/fbr_pkg.sv
package fbr_pkg;

    // request kinds
    localparam logic [1:0] KIND_REPLACE = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_INVAL   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] block_index;
    } t_fbr_in;

    typedef struct packed {
        logic [5:0] victim_index;
        logic       victim_was_free;
        logic [6:0] list_count;
    } t_fbr_out;

    // sequencer -> output stage
    typedef struct packed {
        logic     valid;
        t_fbr_out result;
    } t_fbr_done;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNLINK,
        S_APPEND,
        S_DONE
    } t_fbr_state;

endpackage

>>> sv/fbr_ram.sv
module fbr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fbr_seq.sv
module fbr_seq
    import fbr_pkg::*;
#(
    parameter int NUM_BLOCKS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_fbr_in   i_in_data,
    input  logic      i_take,
    output t_fbr_done o_done
);

    localparam int   IW  = $clog2(NUM_BLOCKS);
    localparam int   CW  = $clog2(NUM_BLOCKS + 1);
    localparam logic BIG = (NUM_BLOCKS >= 64);

    t_fbr_state            r_state, n_state;
    logic [IW-1:0]         r_blk, n_blk;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_fill, n_fill;
    logic [NUM_BLOCKS-1:0] r_listed, n_listed;
    logic [5:0]            r_victim, n_victim;
    logic                  r_free, n_free;

    logic [IW-1:0] tgt;
    logic          next_we, prev_we;
    logic [IW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [IW-1:0] next_rdata, prev_rdata;

    // next / prev links of the doubly linked age list, indexed by block
    fbr_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(IW)) u_next (
        .i_clk  (i_clk),
        .i_we   (next_we),
        .i_waddr(next_waddr),
        .i_wdata(next_wdata),
        .i_raddr(tgt),
        .o_rdata(next_rdata)
    );

    fbr_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(IW)) u_prev (
        .i_clk  (i_clk),
        .i_we   (prev_we),
        .i_waddr(prev_waddr),
        .i_wdata(prev_wdata),
        .i_raddr(tgt),
        .o_rdata(prev_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fill   <= '0;
            r_listed <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_listed <= n_listed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk    <= n_blk;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_victim <= n_victim;
        r_free   <= n_free;
    end

    always_comb begin
        logic go_move;
        go_move    = 1'b0;
        tgt        = IW'(i_in_data.block_index);
        n_state    = r_state;
        n_blk      = r_blk;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_fill     = r_fill;
        n_listed   = r_listed;
        n_victim   = r_victim;
        n_free     = r_free;
        next_we    = 1'b0;
        next_waddr = r_tail;
        next_wdata = r_blk;
        prev_we    = 1'b0;
        prev_waddr = r_blk;
        prev_wdata = r_tail;
        o_in_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                // occupancy is always a prefix: blocks below r_fill are occupied
                if (i_in_data.kind == KIND_REPLACE) begin
                    if (r_fill < CW'(NUM_BLOCKS)) begin
                        tgt     = r_fill[IW-1:0];
                        go_move = 1'b1;
                    end else if (r_count != '0) begin
                        tgt     = r_head;
                        go_move = 1'b1;
                    end
                end else if (i_in_data.kind == KIND_WRITE) begin
                    go_move = BIG || (i_in_data.block_index < 6'(NUM_BLOCKS));
                end
                if (i_in_valid) begin
                    n_blk    = tgt;
                    n_victim = '0;
                    n_free   = 1'b0;
                    n_state  = S_DONE;
                    if (i_in_data.kind == KIND_REPLACE && go_move) begin
                        n_victim = 6'(tgt);
                        if (r_fill < CW'(NUM_BLOCKS)) begin
                            n_free = 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    if (i_in_data.kind == KIND_INVAL) begin
                        n_count  = '0;
                        n_fill   = '0;
                        n_listed = '0;
                    end
                    if (go_move) begin
                        if (!r_listed[tgt]) begin
                            n_state = S_APPEND;
                        end else if (tgt != r_tail) begin
                            n_state = S_UNLINK;
                        end
                    end
                end
            end
            S_UNLINK: begin
                // links of r_blk are on the read ports; r_blk is not the tail
                if (r_blk == r_head) begin
                    n_head = next_rdata;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                end
                prev_we    = 1'b1;
                prev_waddr = next_rdata;
                prev_wdata = prev_rdata;
                n_state    = S_APPEND;
            end
            S_APPEND: begin
                if (r_count == '0) begin
                    n_head = r_blk;
                end else begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
                n_tail = r_blk;
                if (!r_listed[r_blk]) begin
                    n_count         = r_count + 1'b1;
                    n_listed[r_blk] = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done.valid                  = (r_state == S_DONE);
    assign o_done.result.victim_index    = r_victim;
    assign o_done.result.victim_was_free = r_free;
    assign o_done.result.list_count      = 7'(r_count);

endmodule

>>> sv/fifo_block_replacement.sv
// FIFO block replacement unit.
// A replace or write moving a listed block passes UNLINK, APPEND and DONE, an appended block
// APPEND and DONE, and read, invalidate or a block already at the tail DONE alone; the result
// then moves to the output register. The age-list sequencer and its link RAMs handle one
// transaction at a time. Reset (i_rst_n low, synchronous) empties the list and frees every
// block; the link RAMs are not cleared, so no clearing pass is needed.
module fifo_block_replacement
    import fbr_pkg::*;
#(
    parameter int NUM_BLOCKS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_fbr_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_fbr_out o_out_data
);

    // Sequencer: keeps the age list as a doubly linked list in two RAMs
    // (next/prev per block) plus head, tail, count and a per-block "listed"
    // bit. Occupancy never needs a search: blocks are only taken lowest
    // first and only freed all at once, so a fill pointer gives the lowest
    // free block directly.
    t_fbr_done done;
    logic      take;

    // Output register: the finished result moves here so the sequencer can
    // go back to idle while the downstream side stalls.
    logic     r_out_valid;
    t_fbr_out r_out_data;

    assign take = done.valid && (!r_out_valid || i_out_ready);

    fbr_seq #(.NUM_BLOCKS(NUM_BLOCKS)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .i_take    (take),
        .o_done    (done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only changes when a new transaction is loaded
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= done.result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sv/fbr_checker.sv
module fbr_checker
    import fbr_pkg::*;
#(
    parameter int NUM_BLOCKS = 64
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_fbr_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_fbr_out o_out_data
);

`include "fifo_block_replacement_assert.svh"

    // a stalled result holds
    `FBR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // a waiting input transaction holds
    `FBR_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data))

    // one transaction at a time: busy right after an accept
    `FBR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // after a freshly allocated block the list is not empty
    `FBR_ASSERT_SAME(a_free_listed, o_out_valid && o_out_data.victim_was_free,
                     o_out_data.list_count != 7'd0)

    // list never exceeds the number of blocks
    `FBR_ASSERT_SAME(a_count_max, o_out_valid,
                     (NUM_BLOCKS > 127) || (o_out_data.list_count <= 7'(NUM_BLOCKS)))

endmodule

bind fifo_block_replacement fbr_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_fbr_checker (.*);
